### rtl/obv_pkg.sv
// ============================================================================
// obv_pkg: shared types and constants of the orthonormal basis pipeline
// Holds the fixed widths of the normalization datapath, the stage latencies
// of every unit and the vector types passed between the units.
// ============================================================================
package obv_pkg;

   // Prescaled magnitudes keep their leading one at bit MAG_W-1.
   localparam int MAG_W   = 24;
   localparam int PRE_MSB = MAG_W - 1;

   // Result components are signed Q1.14.
   localparam int OUT_W = 16;
   localparam logic [OUT_W-1:0] ONE_Q14 = 16'd16384;

   // Sum of squares and square root widths.
   localparam int SQ_W     = 2 * MAG_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int SQRT_PRE = 12;
   localparam int SQRT_W   = 64;
   localparam int ROOT_W   = 32;
   localparam int SQRT_STEPS = 2;
   localparam int LAT_SQRT   = ROOT_W / SQRT_STEPS;

   // Divider: quotient of (mag << FRAC_SHIFT) + root/2 by root.
   localparam int FRAC_SHIFT = 20;
   localparam int NUM_W      = MAG_W + FRAC_SHIFT + 1;
   localparam int Q_W        = 16;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = Q_W / DIV_STEPS;
   localparam int LAT_DIV    = DIV_STAGES + 1;

   // Stage counts of the prescaler and of one normalization unit.
   localparam int LAT_PRE  = 4;
   localparam int LAT_UNIT = 2 + LAT_SQRT + LAT_DIV + 1;

   // Prescaled vector as sign and magnitude per component.
   typedef struct packed {
      logic [2:0]            sign;
      logic [2:0][MAG_W-1:0] mag;
   } pvec_type;

   // Unit vector, three Q1.14 components.
   typedef logic [2:0][OUT_W-1:0] ovec_type;

   // One result item.
   typedef struct packed {
      ovec_type unit_a;
      ovec_type unit_b;
      ovec_type unit_c;
      logic     degenerate;
   } rsp_data_type;

endpackage

### rtl/obv_if.sv
// ============================================================================
// obv_if: request and response channels
// Valid/ready channels carrying the two input vectors and the result basis.
// ============================================================================
interface obv_req_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] a_x;
   logic signed [W-1:0] a_y;
   logic signed [W-1:0] a_z;
   logic signed [W-1:0] b_x;
   logic signed [W-1:0] b_y;
   logic signed [W-1:0] b_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface obv_rsp_if;
   import obv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] unit_a_x;
   logic signed [OUT_W-1:0] unit_a_y;
   logic signed [OUT_W-1:0] unit_a_z;
   logic signed [OUT_W-1:0] unit_b_x;
   logic signed [OUT_W-1:0] unit_b_y;
   logic signed [OUT_W-1:0] unit_b_z;
   logic signed [OUT_W-1:0] unit_c_x;
   logic signed [OUT_W-1:0] unit_c_y;
   logic signed [OUT_W-1:0] unit_c_z;
   logic                    degenerate;

   modport source (output valid, unit_a_x, unit_a_y, unit_a_z, unit_b_x, unit_b_y,
                   unit_b_z, unit_c_x, unit_c_y, unit_c_z, degenerate, input ready);
   modport sink   (input valid, unit_a_x, unit_a_y, unit_a_z, unit_b_x, unit_b_y,
                   unit_b_z, unit_c_x, unit_c_y, unit_c_z, degenerate, output ready);
endinterface

### rtl/orthonormal_basis_from_two_vectors.sv
// ============================================================================
// orthonormal_basis_from_two_vectors: orthonormal basis from two 3D vectors
// Forms C = A x B and B' = C x A and gives A, B' and C as Q1.14 unit
// vectors, or zero vectors with the degenerate flag when C is zero.
// ============================================================================
//
//   Channel   Direction   Handshake      Contents
//   req_if    in          valid/ready    a_x..a_z, b_x..b_z, Q3.12
//   rsp_if    out         valid/ready    unit_a/b/c x..z Q1.14, degenerate
//
// One item enters per cycle while the skid register is free. The accepting
// edge loads the first of the 41 register stages of the datapath (two cross
// products, two prescalers, the square root and the dividers), and the output
// register is loaded on the edge after the last.
// Reset clears the stage valid bits and the output buffer.
// The datapath halts as a whole only when the output register and its skid
// register both hold items; while the skid register is free, items still enter.
//
module orthonormal_basis_from_two_vectors #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   obv_req_if.sink   req_if,
   obv_rsp_if.source rsp_if
);
   import obv_pkg::*;

   localparam int W    = COMPONENT_WIDTH;
   localparam int PW   = 2 * W;
   localparam int CW   = PW + 1;
   localparam int CSW  = MAG_W + 1;
   localparam int QW   = CSW + W;
   localparam int BW   = QW + 1;
   localparam int T_CS = 3 + LAT_PRE;
   localparam int T_U  = T_CS + 2 + LAT_PRE;
   localparam int LAT  = T_U + LAT_UNIT;

   logic adv;
   logic arriving;
   logic take;

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   logic signed [W-1:0]   in_a_ff [3];
   logic signed [W-1:0]   in_b_ff [3];
   logic signed [PW-1:0]  prod_ff [6];
   logic signed [PW-1:0]  prod_in [6];
   logic signed [CW-1:0]  c_ff [3];
   logic signed [CW-1:0]  c_in [3];
   logic                  deg_ff;
   logic                  deg_in;
   logic                  deg_d;

   pvec_type              ps_c;
   pvec_type              ps_c_d;
   pvec_type              ps_a;
   pvec_type              ps_a_d;
   pvec_type              ps_b;
   logic signed [CSW-1:0] cs [3];
   logic [3*W-1:0]        a_pk;
   logic [3*W-1:0]        a_pk_d;
   logic signed [W-1:0]   a_d [3];
   logic signed [QW-1:0]  bprod_ff [6];
   logic signed [QW-1:0]  bprod_in [6];
   logic signed [BW-1:0]  bp_ff [3];
   logic signed [BW-1:0]  bp_in [3];

   ovec_type              u_a;
   ovec_type              u_b;
   ovec_type              u_c;
   rsp_data_type          pipe_res;
   rsp_data_type          out_ff;
   rsp_data_type          skid_ff;
   logic                  out_v_ff;
   logic                  skid_v_ff;

   // Stall control: the pipeline moves while the skid register is free.
   assign adv          = !skid_v_ff;
   assign req_if.ready = adv;
   assign arriving     = adv && vld_ff[LAT-1];
   assign take         = out_v_ff && rsp_if.ready;
   assign vld_in       = {vld_ff[LAT-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // First cross product C = A x B, products then differences.
   always_comb begin
      prod_in[0] = in_a_ff[1] * in_b_ff[2];
      prod_in[1] = in_a_ff[2] * in_b_ff[1];
      prod_in[2] = in_a_ff[2] * in_b_ff[0];
      prod_in[3] = in_a_ff[0] * in_b_ff[2];
      prod_in[4] = in_a_ff[0] * in_b_ff[1];
      prod_in[5] = in_a_ff[1] * in_b_ff[0];
      for (int i = 0; i < 3; i++) begin
         c_in[i] = CW'(prod_ff[2*i]) - CW'(prod_ff[2*i+1]);
      end
      deg_in = (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_a_ff[0] <= req_if.a_x;
         in_a_ff[1] <= req_if.a_y;
         in_a_ff[2] <= req_if.a_z;
         in_b_ff[0] <= req_if.b_x;
         in_b_ff[1] <= req_if.b_y;
         in_b_ff[2] <= req_if.b_z;
         prod_ff    <= prod_in;
         c_ff       <= c_in;
         deg_ff     <= deg_in;
      end
   end

   // Prescale C; the result feeds both B' and the unit of C.
   obv_prescale #(.IN_W(CW)) u_pre_c (
      .clock (clock),
      .en    (adv),
      .v_in  (c_ff),
      .p_out (ps_c)
   );

   // A waits for the prescaled C.
   assign a_pk = {in_a_ff[2], in_a_ff[1], in_a_ff[0]};

   obv_delay #(.WIDTH(3 * W), .DEPTH(T_CS - 1)) u_adly (
      .clock (clock),
      .en    (adv),
      .d_in  (a_pk),
      .d_out (a_pk_d)
   );

   // Second cross product B' = Cs x A.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_d[i] = a_pk_d[i*W +: W];
         cs[i]  = ps_c.sign[i] ? -$signed({1'b0, ps_c.mag[i]}) : $signed({1'b0, ps_c.mag[i]});
      end
      bprod_in[0] = cs[1] * a_d[2];
      bprod_in[1] = cs[2] * a_d[1];
      bprod_in[2] = cs[2] * a_d[0];
      bprod_in[3] = cs[0] * a_d[2];
      bprod_in[4] = cs[0] * a_d[1];
      bprod_in[5] = cs[1] * a_d[0];
      for (int i = 0; i < 3; i++) begin
         bp_in[i] = BW'(bprod_ff[2*i]) - BW'(bprod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bprod_ff <= bprod_in;
         bp_ff    <= bp_in;
      end
   end

   obv_prescale #(.IN_W(BW)) u_pre_b (
      .clock (clock),
      .en    (adv),
      .v_in  (bp_ff),
      .p_out (ps_b)
   );

   // Prescale A and line up A and C with B'.
   obv_prescale #(.IN_W(W)) u_pre_a (
      .clock (clock),
      .en    (adv),
      .v_in  (in_a_ff),
      .p_out (ps_a)
   );

   obv_delay #(.WIDTH($bits(pvec_type)), .DEPTH(T_U - 1 - LAT_PRE)) u_psa_dly (
      .clock (clock),
      .en    (adv),
      .d_in  (ps_a),
      .d_out (ps_a_d)
   );

   obv_delay #(.WIDTH($bits(pvec_type)), .DEPTH(T_U - T_CS)) u_psc_dly (
      .clock (clock),
      .en    (adv),
      .d_in  (ps_c),
      .d_out (ps_c_d)
   );

   obv_delay #(.WIDTH(1), .DEPTH(LAT - 4)) u_deg_dly (
      .clock (clock),
      .en    (adv),
      .d_in  (deg_ff),
      .d_out (deg_d)
   );

   // Three normalization units in parallel.
   obv_unit u_unit_a (.clock(clock), .en(adv), .p_in(ps_a_d), .u_out(u_a));
   obv_unit u_unit_b (.clock(clock), .en(adv), .p_in(ps_b),   .u_out(u_b));
   obv_unit u_unit_c (.clock(clock), .en(adv), .p_in(ps_c_d), .u_out(u_c));

   // A degenerate item gives zero vectors.
   always_comb begin
      pipe_res.degenerate = deg_d;
      pipe_res.unit_a     = deg_d ? '0 : u_a;
      pipe_res.unit_b     = deg_d ? '0 : u_b;
      pipe_res.unit_c     = deg_d ? '0 : u_c;
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (arriving) begin
         if (!out_v_ff || take) begin
            out_ff   <= pipe_res;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= pipe_res;
            skid_v_ff <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_if.valid      = out_v_ff;
   assign rsp_if.unit_a_x   = out_ff.unit_a[0];
   assign rsp_if.unit_a_y   = out_ff.unit_a[1];
   assign rsp_if.unit_a_z   = out_ff.unit_a[2];
   assign rsp_if.unit_b_x   = out_ff.unit_b[0];
   assign rsp_if.unit_b_y   = out_ff.unit_b[1];
   assign rsp_if.unit_b_z   = out_ff.unit_b[2];
   assign rsp_if.unit_c_x   = out_ff.unit_c[0];
   assign rsp_if.unit_c_y   = out_ff.unit_c[1];
   assign rsp_if.unit_c_z   = out_ff.unit_c[2];
   assign rsp_if.degenerate = out_ff.degenerate;

   // The skid register only fills behind a held output item.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_if.ready))
      else $error("skid register filled while the output register was free");

   // A degenerate item carries zero vectors; the x of A, y of B and z of C are checked.
   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.degenerate) |->
         (rsp_if.unit_a_x == '0 && rsp_if.unit_b_y == '0 && rsp_if.unit_c_z == '0))
      else $error("degenerate item with nonzero components");

   // The derived vector stays within Q1.14 one.
   a_b_range : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         (rsp_if.unit_b_x <= 16'sd16384 && rsp_if.unit_b_x >= -16'sd16384 &&
          rsp_if.unit_b_y <= 16'sd16384 && rsp_if.unit_b_y >= -16'sd16384 &&
          rsp_if.unit_b_z <= 16'sd16384 && rsp_if.unit_b_z >= -16'sd16384))
      else $error("unit component beyond one");

endmodule

### rtl/obv_delay.sv
// ============================================================================
// obv_delay: enabled delay line
// Shifts a payload word through DEPTH registers, advancing only when enabled.
// ============================================================================
module obv_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);
   logic [WIDTH-1:0] line_ff [DEPTH];

   // Shift the line forward by one place.
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign d_out = line_ff[DEPTH-1];
endmodule

### rtl/obv_prescale.sv
// ============================================================================
// obv_prescale: common shift of a 3D vector
// Shifts the three magnitudes by one amount so that the largest has its
// leading one at bit 23; right shifts truncate. Four register stages.
// ============================================================================
module obv_prescale #(
   parameter int IN_W = 33
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [IN_W-1:0] v_in [3],
   output obv_pkg::pvec_type      p_out
);
   import obv_pkg::*;

   localparam int NCH = (IN_W + 7) / 8;
   localparam int OW  = NCH * 8;
   localparam int XW  = IN_W + MAG_W;
   localparam int AW  = $clog2(XW);

   logic [IN_W-1:0] mag1_ff [3];
   logic [IN_W-1:0] mag1_in [3];
   logic [2:0]      sign1_ff;
   logic [OW-1:0]   or1_ff;
   logic [OW-1:0]   or1_in;

   logic [IN_W-1:0] mag2_ff [3];
   logic [2:0]      sign2_ff;
   logic [NCH-1:0]  nz2_ff;
   logic [NCH-1:0]  nz2_in;
   logic [2:0]      lp2_ff [NCH];
   logic [2:0]      lp2_in [NCH];

   logic [IN_W-1:0] mag3_ff [3];
   logic [2:0]      sign3_ff;
   logic            left3_ff;
   logic            left3_in;
   logic [AW-1:0]   amt3_ff;
   logic [AW-1:0]   amt3_in;

   pvec_type        pout_ff;
   pvec_type        pout_in;

   // Magnitudes and the OR of all three, whose leading one is the maximum's.
   always_comb begin
      logic [IN_W-1:0] raw;
      for (int i = 0; i < 3; i++) begin
         raw        = v_in[i];
         mag1_in[i] = raw[IN_W-1] ? (~raw + 1'b1) : raw;
      end
      or1_in = OW'(mag1_in[0] | mag1_in[1] | mag1_in[2]);
   end

   // Leading one inside each byte of the OR word.
   always_comb begin
      for (int j = 0; j < NCH; j++) begin
         nz2_in[j] = |or1_ff[j*8 +: 8];
         lp2_in[j] = '0;
         for (int b = 0; b < 8; b++) begin
            if (or1_ff[j*8 + b]) begin
               lp2_in[j] = 3'(b);
            end
         end
      end
   end

   // Highest nonzero byte gives the position, and from it the shift.
   always_comb begin
      logic [AW-1:0] pos;
      pos = '0;
      for (int j = 0; j < NCH; j++) begin
         if (nz2_ff[j]) begin
            pos = AW'(j * 8) + AW'(lp2_ff[j]);
         end
      end
      left3_in = pos < AW'(PRE_MSB);
      amt3_in  = left3_in ? (AW'(PRE_MSB) - pos) : (pos - AW'(PRE_MSB));
   end

   // Apply the common shift.
   always_comb begin
      logic [XW-1:0] x;
      pout_in.sign = sign3_ff;
      for (int i = 0; i < 3; i++) begin
         x = XW'(mag3_ff[i]);
         x = left3_ff ? (x << amt3_ff) : (x >> amt3_ff);
         pout_in.mag[i] = x[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i]  <= mag1_in[i];
            sign1_ff[i] <= v_in[i][IN_W-1];
         end
         or1_ff   <= or1_in;
         mag2_ff  <= mag1_ff;
         sign2_ff <= sign1_ff;
         nz2_ff   <= nz2_in;
         lp2_ff   <= lp2_in;
         mag3_ff  <= mag2_ff;
         sign3_ff <= sign2_ff;
         left3_ff <= left3_in;
         amt3_ff  <= amt3_in;
         pout_ff  <= pout_in;
      end
   end

   assign p_out = pout_ff;
endmodule

### rtl/obv_isqrt.sv
// ============================================================================
// obv_isqrt: pipelined integer square root
// Floor square root of a 64-bit word, two result bits per register stage.
// ============================================================================
module obv_isqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [obv_pkg::SQRT_W-1:0] n_in,
   output logic [obv_pkg::ROOT_W-1:0] root_out
);
   import obv_pkg::*;

   localparam int REM_W = ROOT_W + 4;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_state_type;

   // One restoring step on the next pair of radicand bits.
   function automatic sq_state_type sqrt_step(input sq_state_type s, input logic [1:0] pair);
      sq_state_type     o;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      rem2  = {s.rem[REM_W-3:0], pair};
      trial = {2'b00, s.root, 2'b01};
      if (rem2 >= trial) begin
         o.rem  = rem2 - trial;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = rem2;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   logic [SQRT_W-1:0] n_ff  [LAT_SQRT];
   sq_state_type      st_ff [LAT_SQRT];

   for (genvar k = 0; k < LAT_SQRT; k++) begin : g_stage
      logic [SQRT_W-1:0] n_prev;
      sq_state_type      st_prev;
      logic [SQRT_W-1:0] n_in_k;
      sq_state_type      st_in;

      if (k == 0) begin : g_first
         assign n_prev  = n_in;
         assign st_prev = '0;
      end else begin : g_next
         assign n_prev  = n_ff[k-1];
         assign st_prev = st_ff[k-1];
      end

      // Two steps per stage.
      always_comb begin
         logic [SQRT_W-1:0] n_cur;
         sq_state_type      st;
         n_cur = n_prev;
         st    = st_prev;
         for (int j = 0; j < SQRT_STEPS; j++) begin
            st    = sqrt_step(st, n_cur[SQRT_W-1 -: 2]);
            n_cur = n_cur << 2;
         end
         n_in_k = n_cur;
         st_in  = st;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]  <= n_in_k;
            st_ff[k] <= st_in;
         end
      end
   end

   assign root_out = st_ff[LAT_SQRT-1].root;
endmodule

### rtl/obv_div.sv
// ============================================================================
// obv_div: pipelined rounding divider
// Computes ((mag << 20) + root/2) / root as a 16-bit quotient, two quotient
// bits per register stage after one stage that forms the numerator.
// ============================================================================
module obv_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [obv_pkg::MAG_W-1:0]  mag_in,
   input  logic [obv_pkg::ROOT_W-1:0] r_in,
   output logic [obv_pkg::Q_W-1:0]    q_out
);
   import obv_pkg::*;

   localparam int P_W = ROOT_W + 1;

   typedef struct packed {
      logic [P_W-1:0]    p;
      logic [Q_W-1:0]    low;
      logic [Q_W-1:0]    q;
      logic [ROOT_W-1:0] r;
   } dv_state_type;

   // One restoring step: bring in the next numerator bit and try to subtract.
   function automatic dv_state_type div_step(input dv_state_type s);
      dv_state_type   o;
      logic [P_W-1:0] p2;
      o  = s;
      p2 = {s.p[P_W-2:0], s.low[Q_W-1]};
      o.low = s.low << 1;
      if (p2 >= P_W'(s.r)) begin
         o.p = p2 - P_W'(s.r);
         o.q = {s.q[Q_W-2:0], 1'b1};
      end else begin
         o.p = p2;
         o.q = {s.q[Q_W-2:0], 1'b0};
      end
      return o;
   endfunction

   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  num_in;
   logic [ROOT_W-1:0] r_ff;
   dv_state_type      st_ff [DIV_STAGES];
   dv_state_type      st0;

   // Numerator with the half-divisor rounding term.
   assign num_in = {1'b0, mag_in, FRAC_SHIFT'(0)} + NUM_W'(r_in >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         r_ff   <= r_in;
      end
   end

   // The quotient fits in Q_W bits, so the upper numerator part starts the remainder.
   always_comb begin
      st0.p   = P_W'(num_ff[NUM_W-1:Q_W]);
      st0.low = num_ff[Q_W-1:0];
      st0.q   = '0;
      st0.r   = r_ff;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      dv_state_type st_prev;
      dv_state_type st_in;

      if (k == 0) begin : g_first
         assign st_prev = st0;
      end else begin : g_next
         assign st_prev = st_ff[k-1];
      end

      always_comb begin
         dv_state_type st;
         st = st_prev;
         for (int j = 0; j < DIV_STEPS; j++) begin
            st = div_step(st);
         end
         st_in = st;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in;
         end
      end
   end

   assign q_out = st_ff[DIV_STAGES-1].q;
endmodule

### rtl/obv_unit.sv
// ============================================================================
// obv_unit: normalization of one prescaled vector
// Squares and sums the components, takes the square root of the scaled sum,
// divides each magnitude by it and clamps the result to Q1.14 one.
// ============================================================================
module obv_unit (
   input  logic              clock,
   input  logic              en,
   input  obv_pkg::pvec_type p_in,
   output obv_pkg::ovec_type u_out
);
   import obv_pkg::*;

   logic [SQ_W-1:0]   sq_ff [3];
   logic [SQ_W-1:0]   sq_in [3];
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [SQRT_W-1:0] n_root;
   logic [ROOT_W-1:0] root;
   pvec_type          p_d;
   logic [Q_W-1:0]    q [3];
   logic [3:0]        side_in;
   logic [3:0]        side_d;
   ovec_type          u_ff;
   ovec_type          u_in;

   // Squares of the magnitudes, then their sum.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = p_in.mag[i] * p_in.mag[i];
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
      end
   end

   // Root of the sum scaled by 2^12.
   assign n_root = SQRT_W'({sum_ff, SQRT_PRE'(0)});

   obv_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .n_in     (n_root),
      .root_out (root)
   );

   // Components wait for the root.
   obv_delay #(.WIDTH($bits(pvec_type)), .DEPTH(2 + LAT_SQRT)) u_pdly (
      .clock (clock),
      .en    (en),
      .d_in  (p_in),
      .d_out (p_d)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      obv_div u_div (
         .clock  (clock),
         .en     (en),
         .mag_in (p_d.mag[i]),
         .r_in   (root),
         .q_out  (q[i])
      );
   end

   // Signs and the zero-root flag travel beside the dividers.
   assign side_in = {root == '0, p_d.sign};

   obv_delay #(.WIDTH(4), .DEPTH(LAT_DIV)) u_sdly (
      .clock (clock),
      .en    (en),
      .d_in  (side_in),
      .d_out (side_d)
   );

   // Clamp to one and apply the sign.
   always_comb begin
      logic [Q_W-1:0] u;
      for (int i = 0; i < 3; i++) begin
         u = (q[i] > ONE_Q14) ? ONE_Q14 : q[i];
         if (side_d[3]) begin
            u_in[i] = '0;
         end else if (side_d[i]) begin
            u_in[i] = OUT_W'(~u + 1'b1);
         end else begin
            u_in[i] = OUT_W'(u);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
      end
   end

   assign u_out = u_ff;
endmodule

### tb/tb_orthonormal_basis_from_two_vectors.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_orthonormal_basis_from_two_vectors: self-checking bench of the basis unit
// Drives vector pairs through the request channel with random gaps. Each
// accepted item has a typed answer or one from a bit-exact fixed-point
// model of the cross products and unit scaling. Results are checked in
// order on the response channel under random and long back-pressure.
// ============================================================================
module tb_orthonormal_basis_from_two_vectors;
   import obv_pkg::*;

   localparam int CW          = 16;
   localparam int N_RANDOM    = 1030;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 180;
   localparam int DRAIN       = 60;
   localparam logic [15:0] Q1 = 16'd16384;

   typedef logic [CW-1:0] comp_t;
   typedef logic [15:0]   q14_t;

   // One expected basis, x/y/z in index 0/1/2.
   typedef struct {
      q14_t ua[3];
      q14_t ub[3];
      q14_t uc[3];
      logic degen;
   } basis_t;

   // Directed row: inputs plus an optional typed answer.
   typedef struct {
      comp_t  a[3];
      comp_t  b[3];
      bit     typed;
      basis_t ans;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   obv_req_if #(.W(CW)) req_if ();
   obv_rsp_if           rsp_if ();

   orthonormal_basis_from_two_vectors #(.COMPONENT_WIDTH(CW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   basis_t pending_bases[$];
   int     mismatches   = 0;
   int     items_in     = 0;
   int     items_out    = 0;
   int     degen_out    = 0;
   int     idle_cycles  = 0;
   bit     stim_done    = 1'b0;
   bit     hold_started = 1'b0;

   // ---------------------------------------------------------------------
   // Fixed-point prediction
   // ---------------------------------------------------------------------
   function automatic void cross_product(input longint p[3], input longint q[3],
                                         output longint o[3]);
      o[0] = p[1] * q[2] - p[2] * q[1];
      o[1] = p[2] * q[0] - p[0] * q[2];
      o[2] = p[0] * q[1] - p[1] * q[0];
   endfunction

   // Shift all magnitudes together until the largest lies in [2^23, 2^24).
   function automatic void shift_to_window(input longint v[3], output longint o[3]);
      longint unsigned mag[3];
      longint unsigned top;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         if (mag[i] > top) top = mag[i];
      end
      if (top != 0) begin
         while (top >= (64'd1 << 24)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         end
         while (top < (64'd1 << 23)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
      end
      for (int i = 0; i < 3; i++) o[i] = (v[i] < 0) ? -longint'(mag[i]) : longint'(mag[i]);
   endfunction

   // Bitwise integer square root, floor.
   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Unit vector in Q1.14, rounded half away from zero, clamped to 1.0.
   function automatic void normalize_q14(input longint v[3], output q14_t o[3]);
      longint          p[3];
      longint unsigned mag[3];
      longint unsigned sum_sq;
      longint unsigned root;
      longint unsigned quo;
      shift_to_window(v, p);
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
         sum_sq += mag[i] * mag[i];
      end
      root = floor_root(sum_sq << 12);
      for (int i = 0; i < 3; i++) begin
         if (root == 0) begin
            o[i] = '0;
         end else begin
            quo = ((mag[i] << 20) + (root >> 1)) / root;
            if (quo > 16384) quo = 16384;
            o[i] = (p[i] < 0) ? q14_t'(-quo) : q14_t'(quo);
         end
      end
   endfunction

   function automatic basis_t predict_basis(input comp_t a_raw[3], input comp_t b_raw[3]);
      basis_t res;
      longint a[3], b[3], c[3], cs[3], bp[3];
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(a_raw[i]));
         b[i] = longint'($signed(b_raw[i]));
      end
      cross_product(a, b, c);
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
         for (int i = 0; i < 3; i++) begin
            res.ua[i] = '0;
            res.ub[i] = '0;
            res.uc[i] = '0;
         end
         res.degen = 1'b1;
         return res;
      end
      shift_to_window(c, cs);
      cross_product(cs, a, bp);
      normalize_q14(a, res.ua);
      normalize_q14(bp, res.ub);
      normalize_q14(c, res.uc);
      res.degen = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Directed rows
   // ---------------------------------------------------------------------
   row_t rows[$];

   function automatic basis_t zero_basis();
      basis_t z;
      for (int i = 0; i < 3; i++) begin
         z.ua[i] = '0;
         z.ub[i] = '0;
         z.uc[i] = '0;
      end
      z.degen = 1'b1;
      return z;
   endfunction

   task automatic add_row(input int ax, ay, az, bx, by, bz, input bit typed,
                          input basis_t ans);
      row_t r;
      r.a[0] = comp_t'(ax); r.a[1] = comp_t'(ay); r.a[2] = comp_t'(az);
      r.b[0] = comp_t'(bx); r.b[1] = comp_t'(by); r.b[2] = comp_t'(bz);
      r.typed = typed;
      r.ans   = ans;
      rows.push_back(r);
   endtask

   task automatic build_rows();
      basis_t none, zero, xyz;
      none = zero_basis();
      zero = zero_basis();
      xyz  = zero_basis();
      xyz.degen = 1'b0;
      xyz.ua[0] = Q1; xyz.ub[1] = Q1; xyz.uc[2] = Q1;
      // Degenerate cases: zeros, one vector zero, parallel, antiparallel.
      add_row(0, 0, 0, 0, 0, 0, 1, zero);
      add_row(4096, 0, 0, 0, 0, 0, 1, zero);
      add_row(0, 0, 0, 0, -32768, 0, 1, zero);
      add_row(100, -200, 300, 200, -400, 600, 1, zero);
      add_row(32767, 32767, 32767, -32767, -32767, -32767, 1, zero);
      add_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, zero);
      // Axis-aligned pairs give the unit axes.
      add_row(4096, 0, 0, 0, 4096, 0, 1, xyz);
      add_row(1, 0, 0, 0, 1, 0, 1, xyz);
      add_row(32767, 0, 0, 0, 32767, 0, 1, xyz);
      // Extremes and mixed signs, checked by the predictor.
      add_row(-32768, 0, 0, 0, -32768, 0, 0, none);
      add_row(-32768, 32767, -32768, 32767, -32768, 32767, 0, none);
      add_row(32767, -32768, 1, -1, 32767, -32768, 0, none);
      add_row(-32768, -32768, -32768, 32767, 32767, -32768, 0, none);
      add_row(1, 1, 1, 1, -1, 0, 0, none);
      add_row(1, 0, 0, 1, 1, 0, 0, none);
      add_row(4096, 4096, 0, 0, 0, -4096, 0, none);
      add_row(32767, 1, 0, 32767, 0, 1, 0, none);
      add_row(-1, -1, -1, -1, -1, 0, 0, none);
      add_row(12345, -23456, 7, -31000, 5, 29999, 0, none);
      add_row(0, 0, 1, 32767, -32768, 0, 0, none);
      // Nearly parallel: tiny cross product, large magnitudes.
      add_row(32767, 32766, 32765, 32766, 32765, 32764, 0, none);
      add_row(-32768, 16384, 0, -32767, 16384, 0, 0, none);
   endtask

   // Random component of a chosen flavor.
   function automatic comp_t rand_comp(input int flavor);
      case (flavor)
         0:       return comp_t'($urandom);
         1:       return comp_t'($urandom_range(0, 16) - 8);
         2:       return comp_t'($urandom_range(0, 8192) - 4096);
         default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: one assignment per signal per falling edge.
   // ---------------------------------------------------------------------
   task automatic offer_item(input comp_t a[3], input comp_t b[3], input bit typed,
                             input basis_t ans);
      int gap;
      gap = $urandom_range(0, 8);
      if (($urandom_range(0, 3) == 0) || hold_started && items_in < 700) gap = 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.a_x <= a[0]; req_if.a_y <= a[1]; req_if.a_z <= a[2];
      req_if.b_x <= b[0]; req_if.b_y <= b[1]; req_if.b_z <= b[2];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_bases.push_back(typed ? ans : predict_basis(a, b));
      items_in++;
      @(negedge clock);
   endtask

   initial begin
      comp_t  a[3], b[3];
      basis_t none;
      int     mode, k;
      none = zero_basis();
      req_if.valid <= 1'b0;
      req_if.a_x <= '0; req_if.a_y <= '0; req_if.a_z <= '0;
      req_if.b_x <= '0; req_if.b_y <= '0; req_if.b_z <= '0;
      build_rows();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (rows[i]) offer_item(rows[i].a, rows[i].b, rows[i].typed, rows[i].ans);
      for (int n = 0; n < N_RANDOM; n++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 3; i++) begin
            a[i] = rand_comp(mode < 5 ? 0 : mode - 5);
            b[i] = rand_comp(mode < 4 ? 0 : $urandom_range(0, 3));
         end
         // Parallel or nearly parallel pair: B is a small multiple of A.
         if (mode == 9) begin
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) begin
               a[i] = comp_t'($urandom_range(0, 8000) - 4000);
               b[i] = comp_t'(k * $signed(a[i]) + ($urandom_range(0, 3) == 0 ? 1 : 0));
            end
         end
         offer_item(a, b, 1'b0, none);
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Response side: random ready, plus one long hold-off to fill the pipe.
   // ---------------------------------------------------------------------
   initial begin
      int wait_cycles;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (!hold_started && items_in >= 300) begin
            hold_started = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Result checker, sampled at the rising edge.
   always @(posedge clock) begin
      basis_t exp_b;
      q14_t   got_a[3], got_b[3], got_c[3];
      bit     bad;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_a = '{rsp_if.unit_a_x, rsp_if.unit_a_y, rsp_if.unit_a_z};
         got_b = '{rsp_if.unit_b_x, rsp_if.unit_b_y, rsp_if.unit_b_z};
         got_c = '{rsp_if.unit_c_x, rsp_if.unit_c_y, rsp_if.unit_c_z};
         items_out++;
         if (rsp_if.degenerate) degen_out++;
         if (pending_bases.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d arrived with none expected", items_out);
         end else begin
            exp_b = pending_bases.pop_front();
            bad = (rsp_if.degenerate !== exp_b.degen);
            for (int i = 0; i < 3; i++)
               bad |= (got_a[i] !== exp_b.ua[i]) || (got_b[i] !== exp_b.ub[i])
                      || (got_c[i] !== exp_b.uc[i]);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected a=%p b=%p c=%p deg=%b, got a=%p b=%p c=%p deg=%b",
                           items_out, exp_b.ua, exp_b.ub, exp_b.uc, exp_b.degen,
                           got_a, got_b, got_c, rsp_if.degenerate);
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // End of run: drain, then report.
   initial begin
      wait (stim_done);
      while (pending_bases.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("ran %0d vector pairs, %0d results (%0d degenerate), long output stall included",
               items_in, items_out, degen_out);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pending_bases.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
rtl/obv_pkg.sv
rtl/obv_if.sv
rtl/obv_delay.sv
rtl/obv_prescale.sv
rtl/obv_isqrt.sv
rtl/obv_div.sv
rtl/obv_unit.sv
rtl/orthonormal_basis_from_two_vectors.sv
tb/tb_orthonormal_basis_from_two_vectors.sv
